@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// Each one expects clk and rst in scope; checks are off while rst is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked on every rising clock edge.
`define FFA_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ffa_pkg.sv @@
// ---------------------------------------------------------------------------
// ffa_pkg
// Constants, codes and interface types of the first-fit free-list allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int ARENA_UNITS = 4096;
  localparam int UNIT_BYTES  = 16;

  localparam int IDX_W      = 13;                    // index, size and count width
  localparam int SUM_W      = IDX_W + 1;             // index plus size
  localparam int BYTES_W    = 16;
  localparam int RND_W      = BYTES_W + 1;
  localparam int ARENA_AW   = $clog2(ARENA_UNITS);
  localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);

  localparam logic [IDX_W-1:0] SENT_IX    = IDX_W'(ARENA_UNITS);
  localparam logic [IDX_W-1:0] WALK_LIMIT = IDX_W'(ARENA_UNITS + 2);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEED,
    S_SEED2,
    S_A_FIRST,
    S_A_WALK,
    S_A_SPLIT,
    S_A_TAIL,
    S_F_ROV,
    S_F_WALK,
    S_F_NX,
    S_F_HI,
    S_F_LOCMP,
    S_F_LO
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [SUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] res;
    logic             zero;
    logic             neg;
  } alu_rsp_t;

  typedef struct packed {
    logic             next_en;
    logic [IDX_W-1:0] next_addr;
    logic [IDX_W-1:0] next_data;
    logic             size_en;
    logic [IDX_W-1:0] size_addr;
    logic [IDX_W-1:0] size_data;
  } hdr_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] sz;
  } hdr_rd_t;

endpackage

`default_nettype wire

@@ hdl/ffa_alu.sv @@
// ---------------------------------------------------------------------------
// ffa_alu
// Shared add/subtract unit with zero and sign flags.
// ---------------------------------------------------------------------------
`default_nettype none

module ffa_alu (
  input  ffa_pkg::alu_req_t req,
  output ffa_pkg::alu_rsp_t rsp
);
  import ffa_pkg::*;

  logic [SUM_W-1:0] res;

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a + req.b;
    endcase
  end

  assign rsp.res  = res;
  assign rsp.zero = (res == '0);
  assign rsp.neg  = res[SUM_W-1];

endmodule

`default_nettype wire

@@ hdl/ffa_hdr_store.sv @@
// ---------------------------------------------------------------------------
// ffa_hdr_store
// Header memories (next index, block size) plus the sentinel's next link.
// One read address, registered read data; separate write ports per array.
// ---------------------------------------------------------------------------
`default_nettype none

module ffa_hdr_store (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ffa_pkg::IDX_W-1:0]   rd_addr,
  input  ffa_pkg::hdr_wr_t            wr,
  output ffa_pkg::hdr_rd_t            rd
);
  import ffa_pkg::*;

  logic [IDX_W-1:0] next_mem [ARENA_UNITS];
  logic [IDX_W-1:0] size_mem [ARENA_UNITS];

  logic [IDX_W-1:0] sentinel_next;
  logic [IDX_W-1:0] next_q;
  logic [IDX_W-1:0] size_q;
  logic [IDX_W-1:0] sent_q;
  logic             rd_sent;
  logic             rd_beyond;

  // arrays: write first-port, read old data
  always_ff @(posedge clk) begin
    if (wr.next_en && (wr.next_addr < SENT_IX)) begin
      next_mem[wr.next_addr[ARENA_AW-1:0]] <= wr.next_data;
    end
    if (wr.size_en && (wr.size_addr < SENT_IX)) begin
      size_mem[wr.size_addr[ARENA_AW-1:0]] <= wr.size_data;
    end
    next_q    <= next_mem[rd_addr[ARENA_AW-1:0]];
    size_q    <= size_mem[rd_addr[ARENA_AW-1:0]];
    sent_q    <= sentinel_next;
    rd_sent   <= (rd_addr == SENT_IX);
    rd_beyond <= (rd_addr > SENT_IX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sentinel_next <= SENT_IX;
    end else if (wr.next_en && (wr.next_addr == SENT_IX)) begin
      sentinel_next <= wr.next_data;
    end
  end

  // sentinel has size zero; anything past it links back to the sentinel
  assign rd.nxt = rd_sent ? sent_q : (rd_beyond ? SENT_IX : next_q);
  assign rd.sz  = (rd_sent || rd_beyond) ? '0 : size_q;

endmodule

`default_nettype wire

@@ hdl/ffa_ctrl.sv @@
// ---------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for allocate and free: list walks, split, address-ordered
// insert with neighbor merge. Drives the shared ALU and the header store.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ffa_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          action,
  input  logic [ffa_pkg::BYTES_W-1:0]   request_bytes,
  input  logic [ffa_pkg::IDX_W-1:0]     user_unit,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [ffa_pkg::IDX_W-1:0]     granted_unit,
  output logic [ffa_pkg::IDX_W-1:0]     granted_units,
  output logic [ffa_pkg::IDX_W-1:0]     rd_addr,
  output ffa_pkg::hdr_wr_t              wr,
  input  ffa_pkg::hdr_rd_t              rd,
  output ffa_pkg::alu_req_t             alu_req,
  input  ffa_pkg::alu_rsp_t             alu_rsp
);
  import ffa_pkg::*;

  state_t state, state_next;

  // control
  logic [IDX_W-1:0] rover, rover_next;
  logic             seeded, seeded_next;
  logic [IDX_W-1:0] steps, steps_next;
  logic             done_next;

  // payload
  logic             act, act_next;
  logic             bad, bad_next;
  logic             oversize, oversize_next;
  logic [IDX_W-1:0] hp, hp_next;
  logic [IDX_W-1:0] n_units, n_units_next;
  logic [IDX_W-1:0] p, p_next;
  logic [IDX_W-1:0] prev, prev_next;
  logic [IDX_W-1:0] diff, diff_next;
  logic [SUM_W-1:0] p2, p2_next;
  logic [IDX_W-1:0] sz_hp, sz_hp_next;
  logic [IDX_W-1:0] sz_p, sz_p_next;
  logic [IDX_W-1:0] sz_pe, sz_pe_next;
  logic [IDX_W-1:0] nx, nx_next;
  logic [IDX_W-1:0] sz_nx, sz_nx_next;
  logic [IDX_W-1:0] nn, nn_next;
  logic [IDX_W-1:0] new_sz, new_sz_next;
  logic [IDX_W-1:0] new_nx, new_nx_next;
  logic             hi, hi_next;
  logic             lo, lo_next;
  logic [1:0]       status_next;
  logic [IDX_W-1:0] gunit_next;
  logic [IDX_W-1:0] gunits_next;

  logic [RND_W-1:0] rnd;
  logic [RND_W-1:0] n_full;
  logic [IDX_W-1:0] steps_inc;
  logic             walk_end;
  logic [IDX_W-1:0] sz_pe_c;

  assign busy = (state != S_IDLE) || rst;

  // units = ceil(bytes / unit) + 1 header unit
  assign rnd       = {1'b0, request_bytes} + RND_W'(UNIT_BYTES - 1);
  assign n_full    = (rnd >> UNIT_SHIFT) + RND_W'(1);
  assign steps_inc = steps + IDX_W'(1);

  // insert position found: hp between p and its next, or at the wrap point
  assign walk_end = ((hp > p) && (hp < rd.nxt)) ||
                    ((p >= rd.nxt) && ((hp > p) || (hp < rd.nxt))) ||
                    (steps_inc >= WALK_LIMIT);

  // size of p as seen after the upper merge (p may alias hp on a bad list)
  assign sz_pe_c = (p == hp) ? new_sz : sz_p;

  always_comb begin
    state_next    = state;
    rover_next    = rover;
    seeded_next   = seeded;
    steps_next    = steps;
    done_next     = 1'b0;
    act_next      = act;
    bad_next      = bad;
    oversize_next = oversize;
    hp_next       = hp;
    n_units_next  = n_units;
    p_next        = p;
    prev_next     = prev;
    diff_next     = diff;
    p2_next       = p2;
    sz_hp_next    = sz_hp;
    sz_p_next     = sz_p;
    sz_pe_next    = sz_pe;
    nx_next       = nx;
    sz_nx_next    = sz_nx;
    nn_next       = nn;
    new_sz_next   = new_sz;
    new_nx_next   = new_nx;
    hi_next       = hi;
    lo_next       = lo;
    status_next   = status;
    gunit_next    = granted_unit;
    gunits_next   = granted_units;
    rd_addr       = rover;
    wr            = '0;
    alu_req.op    = ALU_ADD;
    alu_req.a     = '0;
    alu_req.b     = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          act_next      = action;
          bad_next      = !seeded || (user_unit == '0) || (user_unit > SENT_IX);
          hp_next       = user_unit - IDX_W'(1);
          n_units_next  = n_full[IDX_W-1:0];
          oversize_next = (n_full > RND_W'(ARENA_UNITS));
          state_next    = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (act == ACT_FREE) begin
          if (bad) begin
            done_next   = 1'b1;
            status_next = ST_BAD_FREE;
            gunit_next  = '0;
            gunits_next = '0;
            state_next  = S_IDLE;
          end else begin
            rd_addr    = hp;
            state_next = S_F_ROV;
          end
        end else if (!seeded) begin
          state_next = S_SEED;
        end else if (oversize) begin
          done_next   = 1'b1;
          status_next = ST_NO_SPACE;
          gunit_next  = '0;
          gunits_next = '0;
          state_next  = S_IDLE;
        end else begin
          rd_addr    = rover;
          state_next = S_A_FIRST;
        end
      end

      // whole arena becomes one free block at index 0, linked to the sentinel
      S_SEED: begin
        wr.next_en   = 1'b1;
        wr.next_addr = '0;
        wr.next_data = SENT_IX;
        wr.size_en   = 1'b1;
        wr.size_addr = '0;
        wr.size_data = SENT_IX;
        seeded_next  = 1'b1;
        rover_next   = SENT_IX;
        state_next   = S_SEED2;
      end

      S_SEED2: begin
        wr.next_en   = 1'b1;
        wr.next_addr = SENT_IX;
        wr.next_data = '0;
        state_next   = S_DISPATCH;
      end

      S_A_FIRST: begin
        prev_next  = rover;
        p_next     = rd.nxt;
        steps_next = '0;
        rd_addr    = rd.nxt;
        state_next = S_A_WALK;
      end

      S_A_WALK: begin
        alu_req.op = ALU_SUB;
        alu_req.a  = {1'b0, rd.sz};
        alu_req.b  = {1'b0, n_units};
        if (!alu_rsp.neg) begin
          if (alu_rsp.zero) begin
            // exact fit: unlink
            wr.next_en   = 1'b1;
            wr.next_addr = prev;
            wr.next_data = rd.nxt;
            rover_next   = prev;
            done_next    = 1'b1;
            status_next  = ST_OK;
            gunit_next   = p + IDX_W'(1);
            gunits_next  = n_units;
            state_next   = S_IDLE;
          end else begin
            diff_next  = alu_rsp.res[IDX_W-1:0];
            state_next = S_A_SPLIT;
          end
        end else if ((p == rover) || (steps_inc >= WALK_LIMIT)) begin
          done_next   = 1'b1;
          status_next = ST_NO_SPACE;
          gunit_next  = '0;
          gunits_next = '0;
          state_next  = S_IDLE;
        end else begin
          steps_next = steps_inc;
          prev_next  = p;
          p_next     = rd.nxt;
          rd_addr    = rd.nxt;
        end
      end

      // shrink the free block, grant its top part
      S_A_SPLIT: begin
        alu_req.op   = ALU_ADD;
        alu_req.a    = {1'b0, p};
        alu_req.b    = {1'b0, diff};
        p2_next      = alu_rsp.res;
        wr.size_en   = 1'b1;
        wr.size_addr = p;
        wr.size_data = diff;
        rover_next   = prev;
        state_next   = S_A_TAIL;
      end

      S_A_TAIL: begin
        wr.size_en   = (p2 < {1'b0, SENT_IX});
        wr.size_addr = p2[IDX_W-1:0];
        wr.size_data = n_units;
        done_next    = 1'b1;
        status_next  = ST_OK;
        gunit_next   = p2[IDX_W-1:0] + IDX_W'(1);
        gunits_next  = n_units;
        state_next   = S_IDLE;
      end

      S_F_ROV: begin
        sz_hp_next = rd.sz;
        p_next     = rover;
        steps_next = '0;
        rd_addr    = rover;
        state_next = S_F_WALK;
      end

      S_F_WALK: begin
        rd_addr = rd.nxt;
        if (walk_end) begin
          sz_p_next  = rd.sz;
          nx_next    = rd.nxt;
          state_next = S_F_NX;
        end else begin
          steps_next = steps_inc;
          p_next     = rd.nxt;
        end
      end

      S_F_NX: begin
        sz_nx_next = rd.sz;
        nn_next    = rd.nxt;
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, hp};
        alu_req.b  = {1'b0, sz_hp};
        hi_next    = (nx != SENT_IX) && (alu_rsp.res == {1'b0, nx});
        state_next = S_F_HI;
      end

      // merge with the following block
      S_F_HI: begin
        alu_req.op   = ALU_ADD;
        alu_req.a    = {1'b0, sz_hp};
        alu_req.b    = {1'b0, sz_nx};
        wr.next_en   = 1'b1;
        wr.next_addr = hp;
        if (hi) begin
          new_sz_next  = alu_rsp.res[IDX_W-1:0];
          new_nx_next  = nn;
          wr.size_en   = 1'b1;
          wr.size_addr = hp;
          wr.size_data = alu_rsp.res[IDX_W-1:0];
          wr.next_data = nn;
        end else begin
          new_sz_next  = sz_hp;
          new_nx_next  = nx;
          wr.next_data = nx;
        end
        state_next = S_F_LOCMP;
      end

      S_F_LOCMP: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = {1'b0, p};
        alu_req.b  = {1'b0, sz_pe_c};
        sz_pe_next = sz_pe_c;
        lo_next    = (p != SENT_IX) && (alu_rsp.res == {1'b0, hp});
        state_next = S_F_LO;
      end

      // merge with the preceding block, or just link it to hp
      S_F_LO: begin
        alu_req.op   = ALU_ADD;
        alu_req.a    = {1'b0, sz_pe};
        alu_req.b    = {1'b0, new_sz};
        wr.next_en   = 1'b1;
        wr.next_addr = p;
        if (lo) begin
          wr.size_en   = 1'b1;
          wr.size_addr = p;
          wr.size_data = alu_rsp.res[IDX_W-1:0];
          wr.next_data = new_nx;
        end else begin
          wr.next_data = hp;
        end
        rover_next  = p;
        done_next   = 1'b1;
        status_next = ST_OK;
        gunit_next  = '0;
        gunits_next = '0;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rover  <= SENT_IX;
      seeded <= 1'b0;
      steps  <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      rover  <= rover_next;
      seeded <= seeded_next;
      steps  <= steps_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    act           <= act_next;
    bad           <= bad_next;
    oversize      <= oversize_next;
    hp            <= hp_next;
    n_units       <= n_units_next;
    p             <= p_next;
    prev          <= prev_next;
    diff          <= diff_next;
    p2            <= p2_next;
    sz_hp         <= sz_hp_next;
    sz_p          <= sz_p_next;
    sz_pe         <= sz_pe_next;
    nx            <= nx_next;
    sz_nx         <= sz_nx_next;
    nn            <= nn_next;
    new_sz        <= new_sz_next;
    new_nx        <= new_nx_next;
    hi            <= hi_next;
    lo            <= lo_next;
    status        <= status_next;
    granted_unit  <= gunit_next;
    granted_units <= gunits_next;
  end

  `FFA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
  `FFA_ASSERT_IMP(a_done_follows_work, done, $past(busy), "result without a request in work")
  `FFA_ASSERT_IMP(a_fail_no_grant, done && (status != ST_OK), (granted_unit == '0) && (granted_units == '0), "failed request reports a grant")
  `FFA_ASSERT(a_walk_bound, steps < WALK_LIMIT, "list walk ran past its bound")
  `FFA_ASSERT_IMP(a_wr_busy, wr.next_en || wr.size_en, busy, "header write while idle")

endmodule

`default_nettype wire

@@ hdl/first_fit_free_list_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator
// One request at a time; busy is high from the accepting edge until done.
// Walks visit one header per cycle, set by the single header store read port.
// Allocate: seed on first use, walk, unlink or split. Free: walk, then merges.
// Rejected requests end at dispatch. Next start may be taken in the done cycle.
// done lasts one cycle; the receiver cannot stall.
// Reset (sync, high): list empty, unseeded; header memories are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

// Arena of unit-sized slots managed by a circular, address-ordered free list.
// Each free block begins with a header (next index, size in units). The list
// passes through a size-zero sentinel one index past the arena end; its next
// link lives in a register, everything else in the header store.
//
// Allocate: units = ceil(bytes / unit) + 1 header. The first allocate seeds
// the list with the whole arena as one block. The walk starts after the
// roving pointer and stops at the first block that fits; an exact fit is
// unlinked, a larger block is shrunk and its top part granted. Coming back to
// the rover, or running past the walk bound, reports no space.
//
// Free: the header (user unit minus one) is inserted in address order from
// the rover, then merged with the following block and with the preceding
// block when they touch. The sentinel is never merged. A free before the
// first allocate, or of a unit outside the arena, is rejected.
//
// Block sums, split differences and adjacency checks go through one shared adder.

module first_fit_free_list_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          action,
  input  logic [ffa_pkg::BYTES_W-1:0]   request_bytes,
  input  logic [ffa_pkg::IDX_W-1:0]     user_unit,
  output logic                          busy,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [ffa_pkg::IDX_W-1:0]     granted_unit,
  output logic [ffa_pkg::IDX_W-1:0]     granted_units
);
  import ffa_pkg::*;

  logic [IDX_W-1:0] rd_addr;   // header store read address
  hdr_wr_t          wr;        // header store writes
  hdr_rd_t          rd;        // header read data, registered from rd_addr
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  // sequencer: request transfer, walks, split/merge, result transfer
  ffa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .request_bytes (request_bytes),
    .user_unit     (user_unit),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_unit  (granted_unit),
    .granted_units (granted_units),
    .rd_addr       (rd_addr),
    .wr            (wr),
    .rd            (rd),
    .alu_req       (alu_req),
    .alu_rsp       (alu_rsp)
  );

  // next/size memories and the sentinel link
  ffa_hdr_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd      (rd)
  );

  // the one adder shared by the arithmetic steps
  ffa_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

endmodule

`default_nettype wire

@@ sim/first_fit_free_list_allocator_tb.sv @@
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_tb
// Self-checking bench for the first-fit free-list allocator. Requests go in
// over start/busy. Each result is checked, field by field, against a
// predictor that keeps its own copy of the free list, the sentinel link and
// the rover.
// ---------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffa_pkg::*;

  // One result transfer: what the allocator reports for one request.
  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] unit;
    logic [IDX_W-1:0] units;
  } grant_t;

  localparam int unsigned SENTINEL   = ARENA_UNITS;
  localparam int unsigned WALK_BOUND = int'(WALK_LIMIT);
  localparam int unsigned UU_MAX     = (1 << IDX_W) - 1;

  // DUT ports; every input is known from time zero
  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               start         = 1'b0;
  logic               action        = ACT_ALLOC;
  logic [BYTES_W-1:0] request_bytes = '0;
  logic [IDX_W-1:0]   user_unit     = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic [IDX_W-1:0]   granted_unit;
  logic [IDX_W-1:0]   granted_units;

  first_fit_free_list_allocator DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .action        (action),
    .request_bytes (request_bytes),
    .user_unit     (user_unit),
    .busy          (busy),
    .done          (done),
    .status        (status),
    .granted_unit  (granted_unit),
    .granted_units (granted_units)
  );

  always #5 clk = ~clk;

  // Run limit: far above the slowest legal run, where every request walks
  // a fully fragmented list and the sender idles as much as it can.
  initial begin
    #300ms;
    $display("first_fit_free_list_allocator_tb: FAIL");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Predictor state: header store, sentinel link, rover, seeded flag.
  // -------------------------------------------------------------------------
  int unsigned hdr_next [ARENA_UNITS];
  int unsigned hdr_size [ARENA_UNITS];
  int unsigned sent_link = SENTINEL;
  int unsigned rover     = SENTINEL;
  bit          seeded    = 1'b0;

  grant_t      grant_q[$];   // results still owed by the DUT
  int unsigned live_q[$];    // user units currently handed out
  int unsigned fails = 0;
  bit          quiet = 1'b0; // sender never idles while set

  // Sentinel next lives apart from the store; anything past it reads back
  // as the sentinel and has size zero.
  function automatic int unsigned link_of(int unsigned i);
    if (i == SENTINEL) return sent_link;
    if (i < SENTINEL) return hdr_next[i];
    return SENTINEL;
  endfunction

  function automatic void set_link(int unsigned i, int unsigned v);
    if (i == SENTINEL) sent_link = v;
    else if (i < SENTINEL) hdr_next[i] = v;
  endfunction

  function automatic int unsigned size_of(int unsigned i);
    return (i < SENTINEL) ? hdr_size[i] : 0;
  endfunction

  function automatic void set_size(int unsigned i, int unsigned v);
    if (i < SENTINEL) hdr_size[i] = v;
  endfunction

  // Address-ordered insert from the rover, then merge up and down.
  // The walk is bounded; a bounded-out walk inserts where it stopped.
  function automatic void link_in_block(int unsigned hp);
    int unsigned p;
    int unsigned nx;
    int unsigned steps;
    p     = rover;
    steps = 0;
    forever begin
      nx = link_of(p);
      if (hp > p && hp < nx) break;
      if (p >= nx && (hp > p || hp < nx)) break;
      steps++;
      if (steps >= WALK_BOUND) break;
      p = nx;
    end
    nx = link_of(p);
    // upper neighbor; the sentinel never merges
    if (nx != SENTINEL && hp + size_of(hp) == nx) begin
      set_size(hp, size_of(hp) + size_of(nx));
      set_link(hp, link_of(nx));
    end else begin
      set_link(hp, nx);
    end
    // lower neighbor
    if (p != SENTINEL && p + size_of(p) == hp) begin
      set_size(p, size_of(p) + size_of(hp));
      set_link(p, link_of(hp));
    end else begin
      set_link(p, hp);
    end
    rover = p;
  endfunction

  // Expected result of one accepted request; updates predictor state.
  function automatic grant_t predict_grant(logic act, logic [BYTES_W-1:0] bytes,
                                           logic [IDX_W-1:0] uu);
    grant_t      r;
    int unsigned n;
    int unsigned prev;
    int unsigned p;
    int unsigned sz;
    int unsigned steps;
    r = '0;
    if (act == ACT_ALLOC) begin
      n = (int'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      // first allocate: empty circular list, then the whole arena freed
      if (!seeded) begin
        seeded    = 1'b1;
        sent_link = SENTINEL;
        rover     = SENTINEL;
        set_size(0, SENTINEL);
        link_in_block(0);
      end
      r.status = ST_NO_SPACE;
      if (n <= SENTINEL) begin
        prev  = rover;
        p     = link_of(prev);
        steps = 0;
        forever begin
          sz = size_of(p);
          if (sz >= n) begin
            if (sz == n) begin
              set_link(prev, link_of(p));   // exact fit: unlink
            end else begin
              set_size(p, sz - n);          // split: hand out the top part
              p = p + sz - n;
              set_size(p, n);
            end
            rover    = prev;
            r.status = ST_OK;
            r.unit   = IDX_W'(p + 1);
            r.units  = IDX_W'(n);
            break;
          end
          if (p == rover) break;            // full lap: no space
          steps++;
          if (steps >= WALK_BOUND) break;
          prev = p;
          p    = link_of(p);
        end
      end
    end else begin
      if (!seeded || uu == 0 || uu > SENTINEL) r.status = ST_BAD_FREE;
      else link_in_block(int'(uu) - 1);
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  // -------------------------------------------------------------------------
  // Result checker. done marks one transfer; it is taken at the edge that
  // ends its cycle, so the values sampled here are the ones on the ports.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    grant_t want;
    if (!rst && done) begin
      if (grant_q.size() == 0) begin
        note_failure($sformatf("result with nothing owed: status %0d unit %0d units %0d",
                               status, granted_unit, granted_units));
      end else begin
        want = grant_q.pop_front();
        if (status !== want.status || granted_unit !== want.unit ||
            granted_units !== want.units) begin
          note_failure($sformatf({"result mismatch: status %0d/%0d unit %0d/%0d",
                                  " units %0d/%0d (expected/actual)"},
                                 want.status, status, want.unit, granted_unit,
                                 want.units, granted_units));
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Send one request. start stays high after the accepting edge; the next
  // call either drives the next item straight away or lowers start for a
  // gap, so start gets one update per edge. The field the operation ignores
  // is filled with noise.
  // -------------------------------------------------------------------------
  task automatic issue(input logic act, input logic [BYTES_W-1:0] bytes,
                       input logic [IDX_W-1:0] uu, output grant_t g);
    if (!quiet && $urandom_range(0, 99) < 27) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    if (act == ACT_ALLOC) uu = IDX_W'($urandom);
    else bytes = BYTES_W'($urandom);
    start         <= 1'b1;
    action        <= act;
    request_bytes <= bytes;
    user_unit     <= uu;
    // transfer happens at the first edge that sees busy low
    do @(posedge clk); while (busy);
    g = predict_grant(act, bytes, uu);
    grant_q.push_back(g);
    if (act == ACT_ALLOC && g.status == ST_OK) live_q.push_back(g.unit);
  endtask

  task automatic release_live(input int unsigned idx);
    grant_t g;
    int unsigned uu;
    uu = live_q[idx];
    live_q.delete(idx);
    issue(ACT_FREE, '0, IDX_W'(uu), g);
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Free before the first allocate is rejected and touches nothing.
  task automatic test_unseeded_free();
    grant_t g;
    issue(ACT_FREE, '0, IDX_W'(1), g);
  endtask

  // Seeding on the first allocate, oversized request, and a request that
  // fits the arena but not what is left of it.
  task automatic test_seed_and_oversize();
    grant_t g;
    issue(ACT_ALLOC, '0, '0, g);                       // zero bytes: header only
    issue(ACT_ALLOC, '1, '0, g);                       // more units than the arena
    issue(ACT_ALLOC, BYTES_W'(ARENA_UNITS * UNIT_BYTES - UNIT_BYTES), '0, g);
  endtask

  // Free addresses outside the arena: zero, one past, all ones.
  task automatic test_bad_free_range();
    grant_t g;
    issue(ACT_FREE, '0, '0, g);
    issue(ACT_FREE, '0, IDX_W'(ARENA_UNITS + 1), g);
    issue(ACT_FREE, '0, '1, g);
  endtask

  // Neighboring blocks from splits, freed so that merges happen above,
  // below and on both sides; the top block sits next to the sentinel.
  task automatic test_split_and_merge();
    grant_t a, b, c, d;
    grant_t g;
    issue(ACT_ALLOC, BYTES_W'(16), '0, a);
    issue(ACT_ALLOC, BYTES_W'(17), '0, b);
    issue(ACT_ALLOC, BYTES_W'(1), '0, c);
    issue(ACT_ALLOC, BYTES_W'(100), '0, d);
    // a to d leave the live list here; the top block stays live
    repeat (4) void'(live_q.pop_back());
    issue(ACT_FREE, '0, b.unit, g);                    // no free neighbor
    issue(ACT_FREE, '0, c.unit, g);                    // merges with the block above
    issue(ACT_FREE, '0, a.unit, g);                    // merges with the block below
    issue(ACT_FREE, '0, d.unit, g);                    // merges on both sides
  endtask

  // Whole arena as one exact fit, then an empty list, then put back.
  task automatic test_exact_fit_full();
    grant_t g;
    while (live_q.size() != 0) release_live(0);
    issue(ACT_ALLOC, BYTES_W'(ARENA_UNITS * UNIT_BYTES - UNIT_BYTES), '0, g);
    issue(ACT_ALLOC, '0, '0, g);                       // only the sentinel left
    while (live_q.size() != 0) release_live(0);
  endtask

  // Mostly allocations of small sizes and frees of live blocks, some large
  // and oversized requests, and a share of out-of-arena frees as noise.
  task automatic test_random(input int unsigned count);
    grant_t      g;
    int unsigned pick;
    int unsigned free_pct;
    logic [BYTES_W-1:0] bytes;
    for (int unsigned i = 0; i < count; i++) begin
      quiet    = (i >= count / 3 && i < count / 2);
      free_pct = (live_q.size() > 64) ? 60 : 35;
      pick     = $urandom_range(0, 99);
      if (pick < 6) begin
        issue(ACT_FREE, '0, ($urandom_range(0, 3) == 0) ? IDX_W'(0) :
              IDX_W'($urandom_range(ARENA_UNITS + 1, UU_MAX)), g);
      end else if (live_q.size() != 0 && pick < 6 + free_pct) begin
        release_live($urandom_range(0, live_q.size() - 1));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) bytes = BYTES_W'($urandom_range(0, 160));
        else if (pick < 90) bytes = BYTES_W'($urandom_range(161, 2048));
        else if (pick < 97) bytes = BYTES_W'($urandom_range(2049, 16000));
        else bytes = BYTES_W'($urandom);
        issue(ACT_ALLOC, bytes, '0, g);
      end
    end
    quiet = 1'b0;
  endtask

  // A block freed twice: the second free walks a list that already holds
  // it and must still answer. Run last since the list is damaged after.
  task automatic test_double_free();
    grant_t g, h;
    issue(ACT_ALLOC, BYTES_W'(40), '0, g);
    if (g.status == ST_OK) begin
      void'(live_q.pop_back());
      issue(ACT_FREE, '0, g.unit, h);
      issue(ACT_FREE, '0, g.unit, h);
    end
    issue(ACT_ALLOC, '0, '0, h);
    issue(ACT_ALLOC, BYTES_W'(300), '0, h);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_unseeded_free();
    test_seed_and_oversize();
    test_bad_free_range();
    test_split_and_merge();
    test_exact_fit_full();
    test_random(1270);
    test_double_free();

    start <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    // room for a stray extra result to show up
    repeat (64) @(posedge clk);

    if (fails == 0) begin
      $display("first_fit_free_list_allocator_tb: PASS");
    end else begin
      $display("first_fit_free_list_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
